[hdl/uat_pkg.sv]
package uat_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int UID_BYTES   = 10;

  localparam int DIGIT_W     = 8;
  localparam int LOW_W       = 64;
  localparam int HIGH_W      = 16;
  localparam int UID_W       = LOW_W + HIGH_W;
  localparam int STORE_BYTES = UID_W / DIGIT_W;
  localparam int LEN_W       = 4;
  localparam int MATCH_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } uat_func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_FULL      = 2'd3
  } uat_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CMP,
    ST_RESOLVE,
    ST_UPDATE
  } uat_state_t;

  typedef struct packed {
    uat_func_t          func;
    logic [LEN_W-1:0]   uid_length;
    logic [LOW_W-1:0]   uid_low;
    logic [HIGH_W-1:0]  uid_high;
  } uat_in_t;

  typedef struct packed {
    uat_status_t        status;
    logic               found;
    logic [MATCH_W-1:0] match_index;
    logic [COUNT_W-1:0] entry_count;
  } uat_out_t;

  // Broadcast to every entry cell during a compare pass
  typedef struct packed {
    logic start;
    logic step;
    logic byte_en;
  } uat_cell_ctl_t;

endpackage

[hdl/uat_cell.sv]
module uat_cell (
  input  logic                          clk,
  input  uat_pkg::uat_cell_ctl_t        ctl,
  input  logic [uat_pkg::LEN_W-1:0]     q_len,
  input  logic [uat_pkg::DIGIT_W-1:0]   q_byte,
  input  logic [uat_pkg::UID_W-1:0]     q_uid,
  input  logic                          load,
  input  logic                          pull,
  input  logic [uat_pkg::UID_W-1:0]     next_uid,
  input  logic [uat_pkg::LEN_W-1:0]     next_len,
  output logic [uat_pkg::UID_W-1:0]     uid,
  output logic [uat_pkg::LEN_W-1:0]     len,
  output logic                          match
);

  logic [uat_pkg::UID_W-1:0] uid_r;
  logic [uat_pkg::LEN_W-1:0] len_r;
  logic                      match_r;

  // Entry ring: one byte leaves at the bottom each step and re-enters at the top
  always_ff @(posedge clk) begin
    if (load) begin
      uid_r <= q_uid;
      len_r <= q_len;
    end else if (pull) begin
      uid_r <= next_uid;
      len_r <= next_len;
    end else if (ctl.step) begin
      uid_r <= {uid_r[uat_pkg::DIGIT_W-1:0], uid_r[uat_pkg::UID_W-1:uat_pkg::DIGIT_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      match_r <= (len_r == q_len);
    end else if (ctl.step && ctl.byte_en && (uid_r[uat_pkg::DIGIT_W-1:0] != q_byte)) begin
      match_r <= 1'b0;
    end
  end

  assign uid   = uid_r;
  assign len   = len_r;
  assign match = match_r;

endmodule

[hdl/uid_allowlist_table.sv]
// Allowlist of card identifiers held as a packed table of entry cells. Each cell
// keeps its identifier in a byte-wide ring; a lookup, add or remove compares the
// query against every cell in parallel, one byte per cycle; an operation's result
// is registered after start, ten byte steps, first-match pick and update, and
// a clear goes straight from acceptance to update. Update waits while the
// output register holds a stalled result; the next item can be taken as soon
// as the result appears. One item is processed at a time; a finished result
// waits in the output register while the next item is taken. The table contents
// are undefined after reset, the entry count is zero.
module uid_allowlist_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  uat_pkg::uat_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output uat_pkg::uat_out_t out_data
);

  uat_pkg::uat_state_t          state_r, state_nxt;
  uat_pkg::uat_func_t           func_r, func_nxt;
  logic [uat_pkg::LEN_W-1:0]    qlen_r, qlen_nxt;
  logic [uat_pkg::UID_W-1:0]    quid_r, quid_nxt;
  logic [uat_pkg::UID_W-1:0]    qhold_r, qhold_nxt;
  logic [uat_pkg::LEN_W-1:0]    bcnt_r, bcnt_nxt;
  logic [uat_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         hit_r, hit_nxt;
  logic [uat_pkg::IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  uat_pkg::uat_out_t            out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  uat_pkg::uat_cell_ctl_t       cell_ctl;
  logic                         out_free;
  logic                         upd_go;
  logic                         add_ok;
  logic                         rm_ok;
  logic                         enc_hit;
  logic [uat_pkg::IDX_W-1:0]    enc_idx;

  logic [uat_pkg::MAX_ENTRIES-1:0] cell_match;
  logic [uat_pkg::MAX_ENTRIES-1:0] cell_load;
  logic [uat_pkg::MAX_ENTRIES-1:0] cell_pull;
  logic [uat_pkg::UID_W-1:0]       cell_uid [uat_pkg::MAX_ENTRIES];
  logic [uat_pkg::LEN_W-1:0]       cell_len [uat_pkg::MAX_ENTRIES];

  assign out_free = !out_valid_r || !out_stall;
  assign upd_go   = (state_r == uat_pkg::ST_UPDATE) && out_free;
  assign add_ok   = (func_r == uat_pkg::FUNC_ADD) && !hit_r &&
                    (count_r < uat_pkg::CNT_W'(uat_pkg::MAX_ENTRIES));
  assign rm_ok    = (func_r == uat_pkg::FUNC_REMOVE) && hit_r;

  genvar gi;
  generate
    for (gi = 0; gi < uat_pkg::MAX_ENTRIES; gi++) begin : g_cell
      logic [uat_pkg::UID_W-1:0] nb_uid;
      logic [uat_pkg::LEN_W-1:0] nb_len;

      if (gi + 1 < uat_pkg::MAX_ENTRIES) begin : g_nb
        assign nb_uid = cell_uid[gi+1];
        assign nb_len = cell_len[gi+1];
      end else begin : g_last
        assign nb_uid = cell_uid[gi];
        assign nb_len = cell_len[gi];
      end

      assign cell_load[gi] = upd_go && add_ok && (count_r == uat_pkg::CNT_W'(gi));
      // Close the gap: every entry above the removed one moves down by one
      assign cell_pull[gi] = upd_go && rm_ok &&
                             (uat_pkg::IDX_W'(gi) >= hit_idx_r) &&
                             (uat_pkg::CNT_W'(gi + 1) < count_r);

      uat_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .q_len    (qlen_r),
        .q_byte   (quid_r[uat_pkg::DIGIT_W-1:0]),
        .q_uid    (qhold_r),
        .load     (cell_load[gi]),
        .pull     (cell_pull[gi]),
        .next_uid (nb_uid),
        .next_len (nb_len),
        .uid      (cell_uid[gi]),
        .len      (cell_len[gi]),
        .match    (cell_match[gi])
      );
    end
  endgenerate

  // First matching entry among those in use
  always_comb begin
    enc_hit = 1'b0;
    enc_idx = '0;
    for (int i = uat_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (cell_match[i] && (uat_pkg::CNT_W'(i) < count_r)) begin
        enc_hit = 1'b1;
        enc_idx = uat_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uat_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    qlen_r    <= qlen_nxt;
    quid_r    <= quid_nxt;
    qhold_r   <= qhold_nxt;
    bcnt_r    <= bcnt_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    qlen_nxt      = qlen_r;
    quid_nxt      = quid_r;
    qhold_nxt     = qhold_r;
    bcnt_nxt      = bcnt_r;
    count_nxt     = count_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cell_ctl      = '0;
    in_stall      = (state_r != uat_pkg::ST_IDLE);

    case (state_r)
      uat_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_data.func;
          qlen_nxt  = in_data.uid_length;
          quid_nxt  = {in_data.uid_high, in_data.uid_low};
          qhold_nxt = {in_data.uid_high, in_data.uid_low};
          bcnt_nxt  = '0;
          state_nxt = (in_data.func == uat_pkg::FUNC_CLEAR) ? uat_pkg::ST_UPDATE
                                                             : uat_pkg::ST_START;
        end
      end

      uat_pkg::ST_START: begin
        cell_ctl.start = 1'b1;
        state_nxt      = uat_pkg::ST_CMP;
      end

      uat_pkg::ST_CMP: begin
        cell_ctl.step    = 1'b1;
        cell_ctl.byte_en = (bcnt_r < qlen_r) &&
                           (bcnt_r < uat_pkg::LEN_W'(uat_pkg::UID_BYTES));
        quid_nxt = {quid_r[uat_pkg::DIGIT_W-1:0],
                    quid_r[uat_pkg::UID_W-1:uat_pkg::DIGIT_W]};
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == uat_pkg::LEN_W'(uat_pkg::STORE_BYTES - 1)) begin
          state_nxt = uat_pkg::ST_RESOLVE;
        end
      end

      uat_pkg::ST_RESOLVE: begin
        hit_nxt     = enc_hit;
        hit_idx_nxt = enc_idx;
        state_nxt   = uat_pkg::ST_UPDATE;
      end

      uat_pkg::ST_UPDATE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_nxt.found       = 1'b0;
          out_nxt.match_index = '0;
          out_nxt.status      = uat_pkg::STAT_OK;
          if (func_r == uat_pkg::FUNC_CLEAR) begin
            count_nxt = '0;
          end else begin
            out_nxt.found = hit_r;
            if (hit_r) begin
              out_nxt.match_index = uat_pkg::MATCH_W'(hit_idx_r);
            end
            case (func_r)
              uat_pkg::FUNC_LOOKUP: begin
                out_nxt.status = hit_r ? uat_pkg::STAT_OK : uat_pkg::STAT_NOT_FOUND;
              end
              uat_pkg::FUNC_ADD: begin
                if (hit_r) begin
                  out_nxt.status = uat_pkg::STAT_DUPLICATE;
                end else if (!add_ok) begin
                  out_nxt.status = uat_pkg::STAT_FULL;
                end else begin
                  count_nxt = count_r + 1'b1;
                end
              end
              uat_pkg::FUNC_REMOVE: begin
                if (rm_ok) begin
                  count_nxt = count_r - 1'b1;
                end else begin
                  out_nxt.status = uat_pkg::STAT_NOT_FOUND;
                end
              end
              default: begin
                out_nxt.status = uat_pkg::STAT_OK;
              end
            endcase
          end
          out_nxt.entry_count = uat_pkg::COUNT_W'(count_nxt);
          out_valid_nxt       = 1'b1;
          state_nxt           = uat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = uat_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
